>>> design/swd_pkg.sv
// shared types and constants for the serial wire debug bit sequencer
package swd_pkg;

    // word width of the data path
    localparam int DATA_W = 32;
    // default cap on data bits per request
    localparam int MAX_BITS_DEFAULT = 32;
    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_READ_PAR  = 2'd1;
    localparam logic [1:0] KIND_WRITE     = 2'd2;
    localparam logic [1:0] KIND_WRITE_PAR = 2'd3;

    // period types
    localparam logic [1:0] PT_TURN   = 2'd0;
    localparam logic [1:0] PT_DATA   = 2'd1;
    localparam logic [1:0] PT_PARITY = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_read;
        logic              has_par;
        logic              lead_turn;
        logic [5:0]        nbits;
        logic [DATA_W-1:0] sent;
        logic              wpar;
        logic [DATA_W-1:0] word;
        logic              perr;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_DATA,
        ST_PARITY,
        ST_TAIL
    } seq_state_t;

endpackage

>>> design/swd_front.sv
// front end: accepts requests, tracks line direction, classifies into commands
module swd_front #(
    parameter int MAX_BITS = swd_pkg::MAX_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                kind,
    input  logic [5:0]                bit_count,
    input  logic [31:0]               write_data,
    input  logic [32:0]               target_bits,
    output logic                      q_push,
    output swd_pkg::cmd_t             q_cmd,
    input  logic                      q_full
);
    import swd_pkg::*;

    localparam int LIMIT = (MAX_BITS < DATA_W) ? MAX_BITS : DATA_W;
    localparam logic [5:0] LIMIT_W = 6'(LIMIT);

    logic              host_drives_reg;
    logic              host_drives_next;
    logic              accept;
    logic              is_read;
    logic              has_par;
    logic [5:0]        nbits;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sent;
    logic [DATA_W-1:0] word;
    logic              lead_turn;

    assign full   = q_full;
    assign accept = push && !q_full;

    // decode kind and saturate the bit count
    always_comb
    begin
        is_read   = (kind == KIND_READ) || (kind == KIND_READ_PAR);
        has_par   = (kind == KIND_READ_PAR) || (kind == KIND_WRITE_PAR);
        nbits     = (bit_count > LIMIT_W) ? LIMIT_W : bit_count;
        mask      = DATA_W'((33'd1 << nbits) - 33'd1);
        sent      = write_data & mask;
        word      = target_bits[DATA_W-1:0] & mask;
        lead_turn = is_read ? host_drives_reg : !host_drives_reg;
    end

    // build the command for the back end
    always_comb
    begin
        q_cmd.is_read   = is_read;
        q_cmd.has_par   = has_par;
        q_cmd.lead_turn = lead_turn;
        q_cmd.nbits     = nbits;
        q_cmd.sent      = sent;
        q_cmd.wpar      = ^sent;
        q_cmd.word      = word;
        q_cmd.perr      = (^word) ^ target_bits[nbits];
    end

    // requests with no periods are dropped
    assign q_push = accept && (lead_turn || (nbits != 6'd0) || has_par);

    // line direction left behind by each accepted transaction
    always_comb
    begin
        host_drives_next = host_drives_reg;
        if (accept)
        begin
            host_drives_next = is_read ? has_par : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_drives_reg <= 1'b0;
        end
        else
        begin
            host_drives_reg <= host_drives_next;
        end
    end

endmodule

>>> design/swd_queue.sv
// short command queue between front and back ends
module swd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  swd_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output swd_pkg::cmd_t rd_cmd,
    output logic          q_empty
);
    import swd_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> design/swd_back.sv
// back end: expands one command into serial clock periods
module swd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  swd_pkg::cmd_t rd_cmd,
    input  logic          q_empty,
    output logic          rd_en,
    output logic          empty,
    input  logic          pop,
    output logic          host_drive,
    output logic          line_out,
    output logic [1:0]    period_type,
    output logic          last,
    output logic [31:0]   read_word,
    output logic          parity_error
);
    import swd_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [4:0]        idx_reg;
    logic [4:0]        idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              drive_reg;
    logic              drive_next;
    logic              line_reg;
    logic              line_next;
    logic [1:0]        ptype_reg;
    logic [1:0]        ptype_next;
    logic              last_reg;
    logic              last_next;
    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;
    logic              perr_reg;
    logic              perr_next;
    logic              slot_free;
    logic              fin;

    assign empty        = !out_valid_reg;
    assign host_drive   = drive_reg;
    assign line_out     = line_reg;
    assign period_type  = ptype_reg;
    assign last         = last_reg;
    assign read_word    = word_reg;
    assign parity_error = perr_reg;
    assign slot_free    = !out_valid_reg || pop;

    // sequencer: next state and the period emitted
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        drive_next     = drive_reg;
        line_next      = line_reg;
        ptype_next     = ptype_reg;
        last_next      = last_reg;
        word_next      = word_reg;
        perr_next      = perr_reg;
        rd_en          = 1'b0;
        fin            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    rd_en    = 1'b1;
                    cmd_next = rd_cmd;
                    idx_next = '0;
                    if (rd_cmd.lead_turn)
                    begin
                        state_next = ST_LEAD;
                    end
                    else if (rd_cmd.nbits != 6'd0)
                    begin
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_PARITY;
                    end
                end
            end
            ST_LEAD:
            begin
                if (slot_free)
                begin
                    drive_next = 1'b0;
                    line_next  = 1'b0;
                    ptype_next = PT_TURN;
                    if (cmd_reg.nbits != 6'd0)
                    begin
                        state_next = ST_DATA;
                    end
                    else if (cmd_reg.has_par)
                    begin
                        state_next = ST_PARITY;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    drive_next = !cmd_reg.is_read;
                    line_next  = !cmd_reg.is_read && cmd_reg.sent[idx_reg];
                    ptype_next = PT_DATA;
                    idx_next   = idx_reg + 1'b1;
                    if ({1'b0, idx_reg} == cmd_reg.nbits - 6'd1)
                    begin
                        if (cmd_reg.has_par)
                        begin
                            state_next = ST_PARITY;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            ST_PARITY:
            begin
                if (slot_free)
                begin
                    drive_next = !cmd_reg.is_read;
                    line_next  = !cmd_reg.is_read && cmd_reg.wpar;
                    ptype_next = PT_PARITY;
                    if (cmd_reg.is_read)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    drive_next = 1'b0;
                    line_next  = 1'b0;
                    ptype_next = PT_TURN;
                    fin        = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result register load for any emitted period
        if (state_reg != ST_IDLE && slot_free)
        begin
            out_valid_next = 1'b1;
            last_next      = fin;
            word_next      = (fin && cmd_reg.is_read) ? cmd_reg.word : '0;
            perr_next      = fin && cmd_reg.is_read && cmd_reg.has_par && cmd_reg.perr;
            if (fin)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        drive_reg <= drive_next;
        line_reg  <= line_next;
        ptype_reg <= ptype_next;
        last_reg  <= last_next;
        word_reg  <= word_next;
        perr_reg  <= perr_next;
    end

endmodule

>>> design/swd_bit_sequence_engine.sv
// top level of the serial wire debug bit sequencer
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   request   | push / full        | kind, bit_count, write_data, target_bits
//   period    | pop / empty        | host_drive, line_out, period_type, last,
//             |                    | read_word, parity_error
//
// in the back end sequencer a request first loads its command from the queue,
// then emits one period per cycle into the result register while that register
// is free or being popped; a request has up to 35 periods.
// reset empties the command queue and result register; the line outputs are not reset.
// a held result stalls only the sequencer; the front keeps taking requests
// until the two-entry command queue fills.
module swd_bit_sequence_engine #(
    parameter int MAX_BITS = swd_pkg::MAX_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [5:0]  bit_count,
    input  logic [31:0] write_data,
    input  logic [32:0] target_bits,
    output logic        empty,
    input  logic        pop,
    output logic        host_drive,
    output logic        line_out,
    output logic [1:0]  period_type,
    output logic        last,
    output logic [31:0] read_word,
    output logic        parity_error
);
    import swd_pkg::*;

    cmd_t wr_cmd;
    cmd_t rd_cmd;
    logic q_push;
    logic q_full;
    logic q_empty;
    logic rd_en;

    // request intake and classification
    swd_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .bit_count   (bit_count),
        .write_data  (write_data),
        .target_bits (target_bits),
        .q_push      (q_push),
        .q_cmd       (wr_cmd),
        .q_full      (q_full)
    );

    // command queue
    swd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (wr_cmd),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_cmd  (rd_cmd),
        .q_empty (q_empty)
    );

    // period sequencer
    swd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_cmd       (rd_cmd),
        .q_empty      (q_empty),
        .rd_en        (rd_en),
        .empty        (empty),
        .pop          (pop),
        .host_drive   (host_drive),
        .line_out     (line_out),
        .period_type  (period_type),
        .last         (last),
        .read_word    (read_word),
        .parity_error (parity_error)
    );

endmodule
